FILE: rtl/halfka_feature_extract_sort_assert.svh
// assertion macros for the feature extract and sort block
`ifndef HALFKA_FEATURE_EXTRACT_SORT_ASSERT_SVH
`define HALFKA_FEATURE_EXTRACT_SORT_ASSERT_SVH
`ifndef SYNTHESIS
`define HFS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HFS_ASSERT_SAME(label, ante, cons)
`define HFS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/hfs_pkg.sv
package hfs_pkg;
  localparam int FEAT_W = 16;
  localparam int KING_STRIDE = 704;
  localparam logic [5:0] RANK_FLIP = 6'd56;
  localparam logic [3:0] FIRST_TYPE = 4'd2;
  localparam logic [3:0] LAST_TYPE = 4'd11;
  localparam logic [3:0] EMPTY_CODE = 4'd15;

  typedef enum logic [2:0] {
    S_IDLE, S_KING, S_SCAN, S_FIN, S_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    L_IDLE, L_RD, L_CMP, L_PUT
  } list_state_t;

  function automatic logic [FEAT_W-1:0] king_base(input logic [5:0] k);
    return FEAT_W'(KING_STRIDE * int'(k));
  endfunction
endpackage

FILE: rtl/hfs_ram.sv
module hfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/hfs_list.sv
module hfs_list import hfs_pkg::*; #(
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ins_valid,
  input  logic [$clog2(DEPTH)-1:0] ins_pos,
  input  logic [FEAT_W-1:0]        ins_value,
  input  logic [$clog2(DEPTH)-1:0] emit_addr,
  output logic                     ready,
  output logic [FEAT_W-1:0]        rdata
);
  localparam int AW = $clog2(DEPTH);

  list_state_t state, state_next;
  logic [AW-1:0] pos, pos_next;
  logic [FEAT_W-1:0] value;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [FEAT_W-1:0] wdata;

  hfs_ram #(.WIDTH(FEAT_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
    pos <= pos_next;
    if (state == L_IDLE && ins_valid) begin
      value <= ins_value;
    end
  end

  // insertion: walk down from the fill point, moving larger entries up one
  always_comb begin
    state_next = state;
    pos_next = pos;
    we = 1'b0;
    waddr = pos;
    wdata = value;
    raddr = (state == L_RD) ? pos - AW'(1) : emit_addr;
    ready = (state == L_IDLE);
    case (state)
      L_IDLE: begin
        if (ins_valid) begin
          pos_next = ins_pos;
          state_next = (ins_pos == '0) ? L_PUT : L_RD;
        end
      end
      L_RD: state_next = L_CMP;
      L_CMP: begin
        we = 1'b1;
        if (rdata > value) begin
          wdata = rdata;
          pos_next = pos - AW'(1);
          state_next = (pos == AW'(1)) ? L_PUT : L_RD;
        end else begin
          state_next = L_IDLE;
        end
      end
      L_PUT: begin
        we = 1'b1;
        state_next = L_IDLE;
      end
      default: state_next = L_IDLE;
    endcase
  end
endmodule

FILE: rtl/halfka_feature_extract_sort.sv
// One position per start pulse; busy drops in the cycle that carries the last result pair.
// Runs a king step and a 64-square scan plus, per feature, an insertion that
// moves each entry larger than it in the slower list up one (one ram read and one write
// per move), then a drain step and the emission of the pairs; each list lives in its own
// one-port-read ram.
// Results appear on result_strobe for exactly one cycle each and cannot be
// held off; the last one carries last_pair. At most MAX_FEATURES pairs.
module halfka_feature_extract_sort import hfs_pkg::*; #(
  parameter int MAX_FEATURES = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [63:0]       board_word_0,
  input  logic [63:0]       board_word_1,
  input  logic [63:0]       board_word_2,
  input  logic [63:0]       board_word_3,
  input  logic [5:0]        white_king_square,
  input  logic [5:0]        black_king_square,
  input  logic              black_to_move,
  output logic              result_strobe,
  output logic [FEAT_W-1:0] mover_feature,
  output logic [FEAT_W-1:0] other_feature,
  output logic              last_pair,
  output logic              bad_piece_code
);
  `include "halfka_feature_extract_sort_assert.svh"

  localparam int AW = $clog2(MAX_FEATURES);
  localparam int NW = $clog2(MAX_FEATURES + 1);

  ctrl_state_t state, state_next;
  logic [255:0] board, board_next;
  logic [5:0] wk, bk, sq, sq_next;
  logic btm;
  logic [NW-1:0] n, n_next;
  logic [AW-1:0] k, k_next;
  logic bad, bad_next, strobe_next, last_next;

  logic ins_valid, mover_ready, other_ready, both_ready;
  logic [FEAT_W-1:0] white_val, black_val, mover_val, other_val;
  logic [3:0] code, wtype, btype;
  logic is_piece, is_bad;

  assign code = board[3:0];
  assign is_piece = (code >= FIRST_TYPE) && (code <= LAST_TYPE);
  assign is_bad = (code > LAST_TYPE) && (code != EMPTY_CODE);
  assign wtype = code - 4'd1;
  // black view swaps colors: odd type drops by two
  assign btype = code - {2'b00, code[0], 1'b0};
  assign both_ready = mover_ready && other_ready;
  assign mover_val = btm ? black_val : white_val;
  assign other_val = btm ? white_val : black_val;
  assign busy = (state != S_IDLE);

  always_comb begin
    if (state == S_KING) begin
      white_val = king_base(wk) + {10'd0, bk};
      black_val = king_base(bk) + {10'd0, wk ^ RANK_FLIP};
    end else begin
      white_val = king_base(wk) + {6'd0, wtype, sq};
      black_val = king_base(bk) + {6'd0, btype, sq ^ RANK_FLIP};
    end
  end

  hfs_list #(.DEPTH(MAX_FEATURES)) u_mover (
    .clk(clk), .rst(rst), .ins_valid(ins_valid), .ins_pos(n[AW-1:0]),
    .ins_value(mover_val), .emit_addr(k), .ready(mover_ready), .rdata(mover_feature)
  );

  hfs_list #(.DEPTH(MAX_FEATURES)) u_other (
    .clk(clk), .rst(rst), .ins_valid(ins_valid), .ins_pos(n[AW-1:0]),
    .ins_value(other_val), .emit_addr(k), .ready(other_ready), .rdata(other_feature)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_strobe <= 1'b0;
      n <= '0;
      bad <= 1'b0;
    end else begin
      state <= state_next;
      result_strobe <= strobe_next;
      n <= n_next;
      bad <= bad_next;
    end
    board <= board_next;
    sq <= sq_next;
    k <= k_next;
    last_pair <= last_next;
    if (state == S_IDLE && start) begin
      wk <= white_king_square;
      bk <= black_king_square;
      btm <= black_to_move;
    end
  end

  assign bad_piece_code = bad;

  always_comb begin
    state_next = state;
    board_next = board;
    sq_next = sq;
    n_next = n;
    k_next = k;
    bad_next = bad;
    strobe_next = 1'b0;
    last_next = 1'b0;
    ins_valid = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          board_next = {board_word_3, board_word_2, board_word_1, board_word_0};
          sq_next = '0;
          n_next = '0;
          bad_next = 1'b0;
          state_next = S_KING;
        end
      end
      S_KING: begin
        ins_valid = 1'b1;
        n_next = NW'(1);
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (both_ready) begin
          if (is_piece) begin
            if (n != NW'(MAX_FEATURES)) begin
              ins_valid = 1'b1;
              n_next = n + NW'(1);
            end else begin
              bad_next = 1'b1;
            end
          end
          if (is_bad) begin
            bad_next = 1'b1;
          end
          board_next = board >> 4;
          sq_next = sq + 6'd1;
          if (sq == 6'd63) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (both_ready) begin
          k_next = '0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        strobe_next = 1'b1;
        last_next = (NW'(k) == n - NW'(1));
        if (last_next) begin
          state_next = S_IDLE;
        end else begin
          k_next = k + AW'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `HFS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `HFS_ASSERT_NEXT(a_last_ends, result_strobe && last_pair, !result_strobe)
  `HFS_ASSERT_SAME(a_emit_nonempty, state == S_EMIT, n != '0)
  `HFS_ASSERT_SAME(a_emit_lists_idle, state == S_EMIT, mover_ready && other_ready)
endmodule
